FILE: design/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // Fixed field widths
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned FREE_W = 7;

  // Request kinds on the input tuser bit
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Outcome code of one request
  typedef enum logic [1:0] {
    STATUS_GRANTED  = 2'd0,
    STATUS_RELEASED = 2'd1,
    STATUS_IGNORED  = 2'd2
  } status_e;

  // One result as produced by the slot state logic
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
    logic              evicted;
    logic              clear_block;
    logic [FREE_W-1:0] free_count;
  } result_t;

endpackage : bpa_pkg

`default_nettype wire

FILE: design/bpa_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_core import bpa_pkg::*; #(
  parameter int unsigned BLOCKS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,     // request applied at this edge
  input  wire logic              req_mode_i,
  input  wire logic [SLOT_W-1:0] req_index_i,
  input  wire logic              clear_on_reuse_i,
  output result_t                result_o
);

  localparam int unsigned IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  logic [BLOCKS-1:0] busy_q, busy_d;
  logic [IDX_W-1:0]  rank_q [BLOCKS];
  logic [IDX_W-1:0]  rank_d [BLOCKS];
  logic [FREE_W-1:0] free_q, free_d;

  logic              any_free;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  oldest_idx;
  logic [IDX_W-1:0]  grant_idx;
  logic [IDX_W-1:0]  grant_rank;
  logic              idx_in_range;
  logic [IDX_W-1:0]  rel_idx;
  logic              is_acquire;

  assign is_acquire   = (req_mode_i == MODE_ACQUIRE);
  assign idx_in_range = ({1'b0, req_index_i} < (SLOT_W + 1)'(BLOCKS));
  assign rel_idx      = req_index_i[IDX_W-1:0];
  assign any_free     = ~&busy_q;

  // Lowest-numbered free slot
  always_comb begin
    free_idx = '0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Slot holding rank zero; exactly one slot does
  always_comb begin
    oldest_idx = '0;
    for (int i = 0; i < BLOCKS; i++) begin
      if (rank_q[i] == '0) begin
        oldest_idx = oldest_idx | IDX_W'(i);
      end
    end
  end

  assign grant_idx  = any_free ? free_idx : oldest_idx;
  assign grant_rank = rank_q[grant_idx];

  // Next state: busy flags, ranks, free count
  always_comb begin
    busy_d = busy_q;
    free_d = free_q;
    for (int i = 0; i < BLOCKS; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (is_acquire) begin
      busy_d[grant_idx] = 1'b1;
      if (any_free) begin
        free_d = free_q - FREE_W'(1);
      end
      for (int i = 0; i < BLOCKS; i++) begin
        if (IDX_W'(i) == grant_idx) begin
          rank_d[i] = IDX_W'(BLOCKS - 1);
        end else if (rank_q[i] > grant_rank) begin
          rank_d[i] = rank_q[i] - IDX_W'(1);
        end
      end
    end else if (idx_in_range) begin
      busy_d[rel_idx] = 1'b0;
      if (busy_q[rel_idx]) begin
        free_d = free_q + FREE_W'(1);
      end
    end
  end

  // Result fields
  always_comb begin
    result_o.free_count = free_d;
    if (is_acquire) begin
      result_o.slot        = SLOT_W'(grant_idx);
      result_o.status      = STATUS_GRANTED;
      result_o.evicted     = ~any_free;
      result_o.clear_block = any_free ? clear_on_reuse_i : 1'b1;
    end else if (idx_in_range) begin
      result_o.slot        = req_index_i;
      result_o.status      = STATUS_RELEASED;
      result_o.evicted     = 1'b0;
      result_o.clear_block = clear_on_reuse_i;
    end else begin
      result_o.slot        = req_index_i;
      result_o.status      = STATUS_IGNORED;
      result_o.evicted     = 1'b0;
      result_o.clear_block = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      free_q <= FREE_W'(BLOCKS);
      for (int i = 0; i < BLOCKS; i++) begin
        rank_q[i] <= IDX_W'(i);
      end
    end else if (req_valid_i) begin
      busy_q <= busy_d;
      free_q <= free_d;
      for (int i = 0; i < BLOCKS; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

endmodule : bpa_core

`default_nettype wire

FILE: design/block_pool_allocator_lru_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Block pool allocator with least-recently-acquired eviction.
// Requests enter on the s_axis channel: tuser 0 acquires a slot, tuser 1
// releases the slot in tdata[5:0]. Every request yields exactly one result
// transfer on m_axis with the slot, the status (tuser), the eviction and
// clear flags and the number of free slots after the request.
// An acquire grants the lowest free slot; with the pool full it reuses the
// least recently acquired slot, sets evicted and always asks for a clear.
// Path: a request taken from s_axis lands in the input register, is
// resolved against the slot state and written to the result register
// once that register has room, and is then offered on m_axis.
// Throughput: one request per cycle unless m_axis stalls; the busy flags,
// ranks and free count follow each request, so consecutive ones see each other.
// When m_axis stalls, the result register holds and the input register
// keeps one more request; s_axis tready falls only when both are full.
// cfg_we_i writes clear_on_reuse (reset 1); it is to be used only while idle, which the block does not enforce.
// Reset: all slots free, slot 0 is the oldest, no result pending.
module block_pool_allocator_lru_top import bpa_pkg::*; #(
  parameter int unsigned BLOCKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [5:0] release_index
  input  wire logic        s_axis_tuser,   // [0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [5:0] slot, [6] evicted,
                                           // [7] clear_block, [14:8] free_count
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i
);

  logic              in_valid_q;
  logic              in_mode_q;
  logic [SLOT_W-1:0] in_index_q;
  logic              out_valid_q;
  result_t           out_q;
  result_t           result;
  logic              advance;
  logic              clear_on_reuse_q;

  // Move the input register into the result register when there is room
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_on_reuse_q <= 1'b1;
    end else if (cfg_we_i) begin
      clear_on_reuse_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q  <= s_axis_tuser;
      in_index_q <= s_axis_tdata[SLOT_W-1:0];
    end
  end

  // Slot state and request resolution
  bpa_core #(
    .BLOCKS(BLOCKS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (advance),
    .req_mode_i      (in_mode_q),
    .req_index_i     (in_index_q),
    .clear_on_reuse_i(clear_on_reuse_q),
    .result_o        (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.free_count, out_q.clear_block, out_q.evicted,
                          out_q.slot};
  assign m_axis_tuser  = out_q.status;

  // An eviction only happens on a grant with the pool full, and always clears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.evicted |->
      out_q.status == STATUS_GRANTED && out_q.clear_block && out_q.free_count == '0)
    else $error("eviction result inconsistent");

  // Free count never exceeds the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.free_count <= FREE_W'(BLOCKS))
    else $error("free count above pool size");

  // An ignored release names a slot beyond the pool and asks for no clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == STATUS_IGNORED |->
      {1'b0, out_q.slot} >= (SLOT_W + 1)'(BLOCKS) && !out_q.clear_block)
    else $error("ignored release inconsistent");

  // A request waiting in the input register is resolved once the output frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("pending request not resolved");

endmodule : block_pool_allocator_lru_top

`default_nettype wire
